/* rtl/core/wkct_pkg.sv */
// shared types and codes for the weighted keyed choice table
`timescale 1ns / 1ps
package wkct_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DISABLED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int DRAW_W = 32;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [63:0]       position_key;
    logic [15:0]       move_code;
    logic [15:0]       weight;
    logic [DRAW_W-1:0] draw;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] chosen_move;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] move;
    logic [15:0] weight;
  } entry_t;

endpackage

/* rtl/core/wkct_ram.sv */
// generic simple dual-port ram (one write port, one read port) with registered read
`timescale 1ns / 1ps
module wkct_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/wkct_mod.sv */
// iterative restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module wkct_mod
  import wkct_pkg::*;
#(
  parameter int DW = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DRAW_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [DW-1:0]     rem
);

  localparam int SW = $clog2(DRAW_W);

  logic              busy;
  logic [SW-1:0]     steps;
  logic [DRAW_W-1:0] quo;
  logic [DW:0]       trial;
  logic [DW-1:0]     rem_next;

  always_comb begin
    trial = {rem, quo[DRAW_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DW'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        quo   <= dividend;
        steps <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= {quo[DRAW_W-2:0], 1'b0};
        steps <= steps + 1'b1;
        if (steps == SW'(DRAW_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/weighted_keyed_choice_table_core.sv */
// top level: weighted move table with roulette lookup sequencer
//
//  channel | signals                  | word
//  --------+--------------------------+-------------------------------
//  req     | req_valid, req_ready     | req_t: type, key, move, weight, draw
//  rsp     | rsp_valid, rsp_ready     | rsp_t: status, found, chosen_move
//  cfg     | cfg_valid, cfg_ready     | cfg_data: book_enabled
//
// insert, clear and disabled lookup: straight to S_DONE, which loads the response register once it is free
// lookup: a sum pass over all stored entries, then, for a nonzero matching total, the 32-step remainder
// unit and a pick pass that walks entries until the draw falls; all reads share the single ram read port
// reset empties the table and enables the book; no clearing pass
// req_ready is low while a word is in work; one finished word waits in the
// response register while the next request is taken
`timescale 1ns / 1ps
module weighted_keyed_choice_table_core
  import wkct_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = 16 + CW;
  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_SUM, S_MOD, S_RD2, S_PICK, S_DONE
  } state_t;

  state_t         state;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  idx;
  logic           book_en;
  logic [63:0]    key;
  logic [DRAW_W-1:0] draw;
  logic [TW-1:0]  total;
  logic [TW-1:0]  choice;
  logic           any;
  logic [15:0]    first_move;
  logic [15:0]    last_move;
  rsp_t           res;

  logic           req_fire;
  logic           full;
  logic           ram_we;
  logic           ram_re;
  logic [EW-1:0]  ram_rdata;
  entry_t         rd_entry;
  entry_t         wr_entry;
  logic           hit;
  logic           mod_start;
  logic           mod_done;
  logic [TW-1:0]  mod_rem;
  logic [TW-1:0]  wt_ext;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign full      = (cnt == CW'(ENTRIES));
  assign ram_we    = req_fire && (req.req_type == REQ_INSERT) && !full;
  assign ram_re    = ((state == S_RD1) || (state == S_RD2)) && (idx != cnt);
  assign rd_entry  = ram_rdata;
  assign hit       = (rd_entry.key == key);
  assign wt_ext    = TW'(rd_entry.weight);
  assign mod_start = (state == S_RD1) && (idx == cnt) && any && (total != '0);

  always_comb begin
    wr_entry.key    = req.position_key;
    wr_entry.move   = req.move_code;
    wr_entry.weight = req.weight;
  end

  wkct_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(wr_entry),
    .re   (ram_re),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  wkct_mod #(
    .DW(TW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(draw),
    .divisor (total),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      book_en   <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        book_en <= cfg_data;
      end
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            key   <= req.position_key;
            draw  <= req.draw;
            idx   <= '0;
            total <= '0;
            any   <= 1'b0;
            case (req.req_type)
              REQ_INSERT: begin
                state <= S_DONE;
                if (full) begin
                  res <= '{status: ST_FULL, found: 1'b0, chosen_move: 16'd0};
                end else begin
                  res <= '{status: ST_OK, found: 1'b0, chosen_move: 16'd0};
                  cnt <= cnt + 1'b1;
                end
              end
              REQ_LOOKUP: begin
                if (!book_en) begin
                  res   <= '{status: ST_DISABLED, found: 1'b0, chosen_move: 16'd0};
                  state <= S_DONE;
                end else begin
                  res   <= '{status: ST_OK, found: 1'b0, chosen_move: 16'd0};
                  state <= S_RD1;
                end
              end
              REQ_CLEAR: begin
                res   <= '{status: ST_OK, found: 1'b0, chosen_move: 16'd0};
                cnt   <= '0;
                state <= S_DONE;
              end
              default: begin
                res   <= '{status: ST_OK, found: 1'b0, chosen_move: 16'd0};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD1: begin
          if (idx != cnt) begin
            state <= S_SUM;
          end else if (!any) begin
            res.status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else if (total == '0) begin
            res   <= '{status: ST_OK, found: 1'b1, chosen_move: first_move};
            state <= S_DONE;
          end else begin
            state <= S_MOD;
          end
        end
        S_SUM: begin
          if (hit) begin
            total     <= total + wt_ext;
            last_move <= rd_entry.move;
            any       <= 1'b1;
            if (!any) begin
              first_move <= rd_entry.move;
            end
          end
          idx   <= idx + 1'b1;
          state <= S_RD1;
        end
        S_MOD: begin
          if (mod_done) begin
            choice <= mod_rem + 1'b1;
            idx    <= '0;
            state  <= S_RD2;
          end
        end
        S_RD2: begin
          if (idx != cnt) begin
            state <= S_PICK;
          end else begin
            res   <= '{status: ST_OK, found: 1'b1, chosen_move: last_move};
            state <= S_DONE;
          end
        end
        S_PICK: begin
          if (hit && (choice <= wt_ext)) begin
            res   <= '{status: ST_OK, found: 1'b1, chosen_move: rd_entry.move};
            state <= S_DONE;
          end else begin
            if (hit) begin
              choice <= choice - wt_ext;
            end
            idx   <= idx + 1'b1;
            state <= S_RD2;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == ST_OK)
    else $error("found response with non-ok status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.chosen_move == 16'd0)
    else $error("missed response carries a move");

  a_mod_total: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD |-> total != '0)
    else $error("remainder unit running on zero total");

  a_insert_cnt: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.req_type == REQ_INSERT && !full |=> cnt == $past(cnt) + 1'b1)
    else $error("insert did not advance the entry count");

endmodule
